>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the RTL; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Checked on every rising edge while out of reset.
`define ASSERT_CLKD(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Checked on every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define ASSERT_CLKD(lbl, prop, msg)
`define ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

>>> sv/rsq_pkg.sv
// ----------------------------------------------------------------------------
// Run segment range query package
// Sizes, operation and result codes shared by the run segment query unit.
// ----------------------------------------------------------------------------
package rsq_pkg;

  // String capacity and derived widths.
  localparam int MAX_LEN    = 4096;
  localparam int ADDR_W     = $clog2(MAX_LEN);
  localparam int LEN_W      = ADDR_W + 1;
  localparam int LIST_LIMIT = 10;

  // Field widths of the words.
  localparam int OP_W   = 2;
  localparam int CHAR_W = 8;
  localparam int POS_W  = 13;
  localparam int KIND_W = 2;
  localparam int VAL_W  = 13;

  // Operation codes; code 3 is unused and does nothing.
  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 2'd0,
    OP_QUERY  = 2'd1,
    OP_CLEAR  = 2'd2
  } op_e;

  // Result word kinds.
  typedef enum logic [KIND_W-1:0] {
    KIND_COUNT = 2'd0,
    KIND_CHAR  = 2'd1,
    KIND_ERROR = 2'd2
  } kind_e;

  // Error codes carried in the value field.
  localparam logic [VAL_W-1:0] ERR_OVERFLOW = VAL_W'(0);
  localparam logic [VAL_W-1:0] ERR_RANGE    = VAL_W'(1);

endpackage

>>> sv/run_segment_range_query_unit.sv
// ----------------------------------------------------------------------------
// Run segment range query unit
// Splits an appended byte string into runs and answers range queries.
// ----------------------------------------------------------------------------
// After an append or a clear the unit stays idle and accepts the next word once
// the output register is free. A query reads the run index memory on acceptance
// and in S_RD_HI, loads its count word in S_COUNT, then one run byte per cycle
// while the receiver takes them, for at most 9 listed runs. This order is set by
// the single read port of the run index memory. Reset clears length, run count
// and previous byte; the memories hold no reset value and need no clearing pass.
`include "assert_macros.svh"

module run_segment_range_query_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [rsq_pkg::OP_W-1:0]    op_i,
  input  logic [rsq_pkg::CHAR_W-1:0]  char_in_i,
  input  logic [rsq_pkg::POS_W-1:0]   range_first_i,
  input  logic [rsq_pkg::POS_W-1:0]   range_last_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [rsq_pkg::KIND_W-1:0]  kind_o,
  output logic [rsq_pkg::VAL_W-1:0]   value_o,
  output logic                        last_o
);
  import rsq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_HI,
    S_COUNT,
    S_CHAR_OUT
  } state_e;

  state_e              state_q;
  logic [LEN_W-1:0]    len_q;
  logic [LEN_W-1:0]    total_q;
  logic [CHAR_W-1:0]   prev_q;
  logic [ADDR_W-1:0]   hi_addr_q;
  logic [ADDR_W-1:0]   lo_run_q;
  logic [ADDR_W-1:0]   hi_run_q;
  logic [ADDR_W-1:0]   run_q;
  logic                out_valid_q;
  logic [KIND_W-1:0]   kind_q;
  logic [VAL_W-1:0]    value_q;
  logic                last_q;

  // Memories and their registered read data.
  logic [ADDR_W-1:0]   rop_mem [MAX_LEN];
  logic [CHAR_W-1:0]   chr_mem [MAX_LEN];
  logic [ADDR_W-1:0]   rop_rd_q;
  logic [CHAR_W-1:0]   chr_rd_q;

  logic                out_free;
  logic                accept;
  logic                full;
  logic                bad_range;
  logic                new_run;
  logic                query_start;
  logic                out_load;
  logic [LEN_W-1:0]    total_inc;
  logic [LEN_W-1:0]    count;
  logic                rop_re;
  logic [ADDR_W-1:0]   rop_raddr;
  logic                chr_re;
  logic [ADDR_W-1:0]   chr_raddr;
  logic                rop_we;
  logic                chr_we;

  // Handshake: one word at a time, output register must be free to take an answer.
  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && out_free;
  assign accept     = in_valid_i && in_ready_o;

  // Decode of the incoming word.
  assign full        = (len_q == LEN_W'(MAX_LEN));
  assign bad_range   = (range_first_i == '0) || (range_last_i > len_q) ||
                       (range_first_i > range_last_i);
  assign new_run     = (len_q == '0) || (char_in_i != prev_q);
  assign total_inc   = new_run ? total_q + LEN_W'(1) : total_q;
  assign count       = {1'b0, rop_rd_q} - {1'b0, lo_run_q} + LEN_W'(1);
  assign query_start = accept && (op_i == OP_QUERY) && !bad_range;

  // A new result word enters the output register.
  assign out_load = (accept && (op_i == OP_APPEND) && full) ||
                    (accept && (op_i == OP_QUERY) && bad_range) ||
                    (((state_q == S_COUNT) || (state_q == S_CHAR_OUT)) && out_free);

  // Memory port controls.
  assign rop_we    = accept && (op_i == OP_APPEND) && !full;
  assign chr_we    = rop_we && new_run;
  assign rop_re    = query_start || (state_q == S_RD_HI);
  assign rop_raddr = (state_q == S_RD_HI) ? hi_addr_q : ADDR_W'(range_first_i - POS_W'(1));
  assign chr_re    = ((state_q == S_COUNT) || (state_q == S_CHAR_OUT)) && out_free;
  assign chr_raddr = (state_q == S_COUNT) ? lo_run_q : run_q + ADDR_W'(1);

  // Run index memory: writes only when idle, reads only during a query.
  always_ff @(posedge clk_i) begin
    if (rop_we) begin
      rop_mem[len_q[ADDR_W-1:0]] <= ADDR_W'(total_inc - LEN_W'(1));
    end
    if (rop_re) begin
      rop_rd_q <= rop_mem[rop_raddr];
    end
  end

  // Run byte memory; the next byte is prefetched while the current one is shown.
  always_ff @(posedge clk_i) begin
    if (chr_we) begin
      chr_mem[total_q[ADDR_W-1:0]] <= char_in_i;
    end
    if (chr_re) begin
      chr_rd_q <= chr_mem[chr_raddr];
    end
  end

  // Sequencer, string state and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      len_q       <= '0;
      total_q     <= '0;
      prev_q      <= '0;
      hi_addr_q   <= '0;
      lo_run_q    <= '0;
      hi_run_q    <= '0;
      run_q       <= '0;
      out_valid_q <= 1'b0;
      kind_q      <= KIND_COUNT;
      value_q     <= '0;
      last_q      <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            case (op_i)
              OP_APPEND: begin
                if (full) begin
                  kind_q      <= KIND_ERROR;
                  value_q     <= ERR_OVERFLOW;
                  last_q      <= 1'b1;
                end else begin
                  len_q   <= len_q + LEN_W'(1);
                  total_q <= total_inc;
                  prev_q  <= char_in_i;
                end
              end
              OP_QUERY: begin
                if (bad_range) begin
                  kind_q      <= KIND_ERROR;
                  value_q     <= ERR_RANGE;
                  last_q      <= 1'b1;
                end else begin
                  hi_addr_q <= ADDR_W'(range_last_i - POS_W'(1));
                  state_q   <= S_RD_HI;
                end
              end
              OP_CLEAR: begin
                len_q   <= '0;
                total_q <= '0;
                prev_q  <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        S_RD_HI: begin
          lo_run_q <= rop_rd_q;
          state_q  <= S_COUNT;
        end
        S_COUNT: begin
          if (out_free) begin
            kind_q      <= KIND_COUNT;
            value_q     <= VAL_W'(count);
            hi_run_q    <= rop_rd_q;
            run_q       <= lo_run_q;
            if (count >= LEN_W'(LIST_LIMIT)) begin
              last_q  <= 1'b1;
              state_q <= S_IDLE;
            end else begin
              last_q  <= 1'b0;
              state_q <= S_CHAR_OUT;
            end
          end
        end
        S_CHAR_OUT: begin
          if (out_free) begin
            kind_q      <= KIND_CHAR;
            value_q     <= VAL_W'(chr_rd_q);
            last_q      <= (run_q == hi_run_q);
            run_q       <= run_q + ADDR_W'(1);
            if (run_q == hi_run_q) begin
              state_q <= S_IDLE;
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign value_o     = value_q;
  assign last_o      = last_q;

  // Checks on the string state and the query sequencer.
  `ASSERT_ALWAYS(a_len_bound, !rst_ni || (len_q <= LEN_W'(MAX_LEN)), "length exceeds capacity")
  `ASSERT_ALWAYS(a_runs_le_len, !rst_ni || (total_q <= len_q), "more runs than characters")
  `ASSERT_CLKD(a_list_in_range, (state_q == S_CHAR_OUT) |-> (run_q <= hi_run_q), "run past end")
  `ASSERT_CLKD(a_query_starts, query_start |=> (state_q == S_RD_HI), "query did not start")
  `ASSERT_CLKD(a_clear_empties, (accept && (op_i == OP_CLEAR)) |=> (len_q == '0), "clear left data")

endmodule

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// Run segment range query unit testbench
// Appends bytes, clears the string and asks range queries through the input
// handshake, and checks every result word against a run segmentation kept in
// the bench, with random idling on both sides and long receiver hold-offs.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rsq_pkg::*;

  // Code 3 is accepted and ignored by the block.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 500_000;
  localparam int SETTLE_CYCLES = 20;

  // One expected result word.
  typedef struct {
    kind_e             kind;
    logic [VAL_W-1:0]  value;
    logic              last;
  } answer_t;

  logic clk_i = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic [OP_W-1:0] op_w = OP_CLEAR;
  logic [CHAR_W-1:0] char_w = '0;
  logic [POS_W-1:0] first_w = '0;
  logic [POS_W-1:0] last_w = '0;
  logic out_ready = 1'b0;
  logic in_ready_o;
  logic out_valid_o;
  logic [KIND_W-1:0] kind_o;
  logic [VAL_W-1:0] value_o;
  logic last_o;

  // Shadow copy of the string segmentation.
  logic [ADDR_W-1:0] seg_run_index [MAX_LEN];
  logic [CHAR_W-1:0] seg_run_byte [MAX_LEN];
  logic [LEN_W-1:0] seg_len = '0;
  logic [LEN_W-1:0] seg_runs = '0;
  logic [CHAR_W-1:0] seg_prev_byte = '0;

  answer_t expected_answers[$];
  answer_t head;
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  int unsigned long_hold_req = 0;
  bit calm = 1'b0;

  run_segment_range_query_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready_o),
    .op_i          (op_w),
    .char_in_i     (char_w),
    .range_first_i (first_w),
    .range_last_i  (last_w),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready),
    .kind_o        (kind_o),
    .value_o       (value_o),
    .last_o        (last_o)
  );

  // 20 ns clock.
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Global watchdog.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Idle length for either side: mostly none or short, now and then long.
  function automatic int unsigned idle_gap();
    int unsigned pick;
    if (calm) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [POS_W-1:0] noise_pos();
    return POS_W'($urandom_range(0, 2 ** POS_W - 1));
  endfunction

  function automatic void push_answer(kind_e kind, logic [VAL_W-1:0] value, logic last);
    answer_t a;
    a.kind = kind;
    a.value = value;
    a.last = last;
    expected_answers.insert(expected_answers.size(), a);
  endfunction

  // Applies one accepted word to the shadow string and queues its answers.
  function automatic void segment_and_answer(logic [OP_W-1:0] op_code,
                                             logic [CHAR_W-1:0] ch,
                                             logic [POS_W-1:0] first,
                                             logic [POS_W-1:0] lastp);
    logic [ADDR_W-1:0] lo_run;
    logic [ADDR_W-1:0] hi_run;
    logic [VAL_W-1:0] count;
    int r;
    case (op_code)
      OP_APPEND: begin
        if (seg_len == LEN_W'(MAX_LEN)) begin
          push_answer(KIND_ERROR, ERR_OVERFLOW, 1'b1);
        end else begin
          // A new run opens on an empty string or on a change of byte.
          if (seg_len == '0 || ch != seg_prev_byte) begin
            seg_run_byte[seg_runs[ADDR_W-1:0]] = ch;
            seg_runs = seg_runs + 1'b1;
          end
          seg_run_index[seg_len[ADDR_W-1:0]] = ADDR_W'(seg_runs - 1'b1);
          seg_len = seg_len + 1'b1;
          seg_prev_byte = ch;
        end
      end
      OP_QUERY: begin
        if (first == '0 || lastp > seg_len || first > lastp) begin
          push_answer(KIND_ERROR, ERR_RANGE, 1'b1);
        end else begin
          lo_run = seg_run_index[ADDR_W'(first - 1'b1)];
          hi_run = seg_run_index[ADDR_W'(lastp - 1'b1)];
          count = VAL_W'(hi_run) - VAL_W'(lo_run) + 1'b1;
          if (count >= VAL_W'(LIST_LIMIT)) begin
            push_answer(KIND_COUNT, count, 1'b1);
          end else begin
            push_answer(KIND_COUNT, count, 1'b0);
            for (r = lo_run; r <= hi_run; r++) begin
              push_answer(KIND_CHAR, VAL_W'(seg_run_byte[r]), r == hi_run);
            end
          end
        end
      end
      OP_CLEAR: begin
        seg_len = '0;
        seg_runs = '0;
        seg_prev_byte = '0;
      end
      default: begin
      end
    endcase
  endfunction

  // Offers one word, waits for its acceptance, then idles for a while.
  task automatic send_word(input logic [OP_W-1:0] op_code, input logic [CHAR_W-1:0] ch,
                           input logic [POS_W-1:0] first, input logic [POS_W-1:0] lastp);
    int unsigned gap;
    in_valid <= 1'b1;
    op_w <= op_code;
    char_w <= ch;
    first_w <= first;
    last_w <= lastp;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    segment_and_answer(op_code, ch, first, lastp);
    gap = idle_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_query(input int unsigned first, input int unsigned lastp);
    send_word(OP_QUERY, CHAR_W'($urandom_range(0, 255)), POS_W'(first), POS_W'(lastp));
  endtask

  task automatic send_append(input logic [CHAR_W-1:0] ch);
    send_word(OP_APPEND, ch, noise_pos(), noise_pos());
  endtask

  task automatic send_clear();
    send_word(OP_CLEAR, CHAR_W'($urandom_range(0, 255)), noise_pos(), noise_pos());
  endtask

  // Query inside the stored string, often a short range so that bytes get listed.
  task automatic send_query_inside();
    int unsigned first;
    int unsigned lastp;
    first = $urandom_range(1, seg_len);
    if ($urandom_range(0, 1) == 0) begin
      lastp = first + $urandom_range(0, 12);
      if (lastp > seg_len) lastp = seg_len;
    end else begin
      lastp = $urandom_range(first, seg_len);
    end
    send_query(first, lastp);
  endtask

  // Stops offering words and waits until every expected word has come back.
  task automatic drain_answers();
    in_valid <= 1'b0;
    while (expected_answers.size() != 0) @(posedge clk_i);
  endtask

  // Receiver: random stalls, plus a long hold-off when one is requested.
  initial begin : receiver
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (long_hold_req != 0) begin
        stall_left = long_hold_req;
        long_hold_req = 0;
      end
      if (stall_left == 0) stall_left = idle_gap();
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Compares every accepted result word with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_n && out_valid_o === 1'b1 && out_ready) begin
      if (expected_answers.size() == 0) begin
        $error("result word with none expected: kind %0d value %0d last %0d",
               kind_o, value_o, last_o);
        fail_count++;
      end else begin
        head = expected_answers.pop_front();
        if (kind_o !== head.kind) begin
          $error("kind mismatch: expected %0d, actual %0d", head.kind, kind_o);
          fail_count++;
        end
        if (value_o !== head.value) begin
          $error("value mismatch: expected %0d, actual %0d", head.value, value_o);
          fail_count++;
        end
        if (last_o !== head.last) begin
          $error("last mismatch: expected %0d, actual %0d", head.last, last_o);
          fail_count++;
        end
      end
    end
  end

  // Every query on an empty string is a bad range; unused op and clear are silent.
  task automatic test_empty_string();
    send_query(1, 1);
    send_query(0, 0);
    send_word(OP_UNUSED, 8'hA5, noise_pos(), noise_pos());
    send_clear();
    send_query(1, 0);
    drain_answers();
  endtask

  // Byte extremes, a zero byte on an empty string, and each bad range form.
  task automatic test_runs_and_ranges();
    send_append(8'h00);
    send_append(8'h00);
    send_append(8'hFF);
    send_append(8'hFF);
    send_append(8'hFF);
    send_append(8'h41);
    send_append(8'h00);
    send_query(1, 7);
    send_query(3, 3);
    send_query(2, 3);
    send_query(0, 3);
    send_query(1, 8);
    send_query(5, 4);
    send_query(2 ** POS_W - 1, 2 ** POS_W - 1);
    drain_answers();
  endtask

  // Run counts just below and at the listing limit.
  task automatic test_long_answer();
    int i;
    send_clear();
    for (i = 1; i <= LIST_LIMIT; i++) send_append(CHAR_W'(i));
    send_query(1, LIST_LIMIT);
    send_query(1, LIST_LIMIT - 1);
    send_query(2, LIST_LIMIT);
    drain_answers();
  endtask

  // Long receiver hold-off while queries keep coming, so the block backs up.
  task automatic test_backpressure();
    int i;
    send_clear();
    for (i = 0; i < 20; i++) send_append(CHAR_W'($urandom_range(0, 255)));
    calm = 1'b1;
    long_hold_req = 300;
    for (i = 0; i < 25; i++) send_query_inside();
    calm = 1'b0;
    drain_answers();
  endtask

  // Mostly bursts of appends followed by valid queries, with some noise words.
  task automatic test_random_traffic();
    int unsigned words;
    int unsigned n;
    logic [OP_W-1:0] op_code;
    logic [CHAR_W-1:0] ch;
    words = 0;
    while (words < 50) begin
      // A stretch in the middle runs with no idling on either side.
      calm = (words >= 20 && words < 35);
      if ($urandom_range(0, 99) < 85) begin
        if ($urandom_range(0, 9) == 0 || seg_len > 3000) begin
          send_clear();
          words++;
        end
        n = $urandom_range(1, 8);
        ch = seg_prev_byte;
        repeat (n) begin
          if ($urandom_range(0, 2) == 0) ch = CHAR_W'($urandom_range(0, 255));
          send_append(ch);
          words++;
        end
        n = $urandom_range(1, 3);
        repeat (n) begin
          if (seg_len != '0) begin
            send_query_inside();
            words++;
          end
        end
      end else begin
        op_code = OP_W'($urandom_range(0, 3));
        send_word(op_code, CHAR_W'($urandom_range(0, 255)), noise_pos(), noise_pos());
        if (op_code != OP_UNUSED) words++;
      end
    end
    calm = 1'b0;
    drain_answers();
  endtask

  // Test sequence.
  initial begin
    repeat (11) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);
    test_empty_string();
    test_runs_and_ranges();
    test_long_answer();
    test_backpressure();
    test_random_traffic();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
